### rtl/core/hvm_pkg.sv
`default_nettype none

package hvm_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_STRENGTH = 2'd0,
        KIND_REMAP    = 2'd1,
        KIND_TRACK    = 2'd2,
        KIND_UPDATE   = 2'd3
    } kind_t;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE_MASK   = 1'b0;
    localparam logic REG_SAMPLE_PERIOD = 1'b1;

    localparam int LEVEL_W   = 16;
    localparam int MASK_W    = 4;
    localparam int PERIOD_W  = 20;
    localparam int DIV_W     = 21;  // accumulator plus elapsed time
    localparam int DIV_CNT_W = 5;

    localparam logic [LEVEL_W-1:0]  Q_ONE          = 16'd32768;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 20'd62500;

    // controller to datapath
    typedef struct packed {
        logic init;    // reset clearing sweep
        logic accept;  // item taken this cycle
        logic trk_wr;  // track merge write back
        logic div;     // one quotient bit
        logic setup;   // load clear and emit counters
        logic clr;     // clear one ring entry
        logic emit;    // issue one drive lookup
    } hvm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic trk_ok;
        logic div_last;
        logic clr_zero;
        logic clr_last;
        logic emit_last;
    } hvm_stat_t;

endpackage

`default_nettype wire

### rtl/core/hvm_ram.sv
`default_nettype none

module hvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/hvm_ctrl.sv
`default_nettype none

module hvm_ctrl
    import hvm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] kind,
    input  wire hvm_stat_t  stat,
    output hvm_cmd_t        cmd,
    output logic            busy
);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_TRK   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_SETUP = 8'b0001_0000,
        S_CLR   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_DRAIN = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (kind == KIND_TRACK && stat.trk_ok)
                    begin
                        state_next = S_TRK;
                    end
                    else if (kind == KIND_UPDATE)
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_TRK:
            begin
                cmd.trk_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.clr_zero ? S_EMIT : S_CLR;
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/hvm_datapath.sv
`default_nettype none

module hvm_datapath
    import hvm_pkg::*;
#(
    parameter int CONTROLLERS = 4,
    parameter int MOTORS      = 2,
    parameter int RING_DEPTH  = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hvm_cmd_t              cmd,
    output hvm_stat_t                  stat,
    input  wire logic [1:0]            kind,
    input  wire logic [1:0]            controller,
    input  wire logic                  motor,
    input  wire logic [LEVEL_W-1:0]    level,
    input  wire logic [15:0]           scale,
    input  wire logic [5:0]            offset,
    input  wire logic signed [2:0]     physical,
    input  wire logic [PERIOD_W-1:0]   elapsed_us,
    input  wire logic [MASK_W-1:0]     enable_mask,
    input  wire logic [PERIOD_W-1:0]   sample_period_us,
    output logic                       valid,
    output logic [1:0]                 physical_out,
    output logic                       motor_out,
    output logic [LEVEL_W-1:0]         drive,
    output logic                       last
);

    localparam int CW  = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
    localparam int MW  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int SW  = $clog2(RING_DEPTH);
    localparam int AW  = CW + MW + SW;
    localparam int CLW = $clog2(RING_DEPTH + 1);

    localparam logic [CW-1:0]  C_LAST = CW'(CONTROLLERS - 1);
    localparam logic [MW-1:0]  M_LAST = MW'(MOTORS - 1);
    localparam logic [SW-1:0]  S_LAST = SW'(RING_DEPTH - 1);
    localparam logic [SW:0]    DEPTH_X = (SW + 1)'(RING_DEPTH);

    // state
    logic [LEVEL_W-1:0] str_reg       [CONTROLLERS][MOTORS];
    logic               map_valid_reg [CONTROLLERS];
    logic [CW-1:0]      map_idx_reg   [CONTROLLERS];
    logic               map_valid_next[CONTROLLERS];
    logic [CW-1:0]      map_idx_next  [CONTROLLERS];
    logic [SW-1:0]      pos_reg;
    logic [PERIOD_W-1:0] acc_reg;

    // sequencing
    logic [AW-1:0]        init_cnt_reg;
    logic [AW-1:0]        trk_addr_reg;
    logic [31:0]          prod_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [SW-1:0]        qmod_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [CW-1:0]        clr_c_reg;
    logic [MW-1:0]        clr_m_reg;
    logic [SW-1:0]        clr_slot_reg;
    logic [CLW-1:0]       clr_left_reg;
    logic [CW-1:0]        emit_p_reg;
    logic [MW-1:0]        emit_m_reg;

    // emission stage
    logic               st_valid_reg;
    logic [CW-1:0]      st_p_reg;
    logic [MW-1:0]      st_m_reg;
    logic               st_hit_reg;
    logic [LEVEL_W-1:0] st_str_reg;
    logic               st_last_reg;

    // decode
    logic               ctl_ok, mot_ok, off_ok;
    logic [CW-1:0]      ctl_i;
    logic [MW-1:0]      mot_i;
    logic [1:0]         phys_p;
    logic [LEVEL_W-1:0] level_sat;
    logic [SW:0]        slot_sum;
    logic [SW-1:0]      slot;
    logic [AW-1:0]      trk_addr;
    logic [LEVEL_W-1:0] trk_v;
    logic [LEVEL_W-1:0] trk_new;
    logic               found;

    // divider
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   rem_sh;
    logic                q_bit;
    logic [PERIOD_W-1:0] rem_nx;
    logic [SW:0]         qmod_sh;
    logic [SW-1:0]       qmod_nx;
    logic [SW:0]         pos_sum;
    logic [SW-1:0]       pos_nx;

    // clear and emit
    logic          clr_m_last, clr_c_last;
    logic          emit_m_last, emit_p_last;
    logic [CW-1:0] sel_c;
    logic          sel_hit;

    // ring memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [LEVEL_W-1:0] ram_rdata;

    hvm_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (2 ** AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // item decode
    always_comb
    begin
        ctl_ok    = int'(controller) < CONTROLLERS;
        mot_ok    = int'(motor) < MOTORS;
        off_ok    = int'(offset) < RING_DEPTH;
        ctl_i     = CW'(controller);
        mot_i     = MW'(motor);
        phys_p    = physical[1:0];
        level_sat = (level > Q_ONE) ? Q_ONE : level;
        slot_sum  = {1'b0, pos_reg} + (SW + 1)'(offset) + (SW + 1)'(1);
        slot      = (slot_sum >= DEPTH_X) ? SW'(slot_sum - DEPTH_X) : SW'(slot_sum);
        trk_addr  = {ctl_i, mot_i, slot};
        trk_v     = (prod_reg[31:8] > 24'(Q_ONE)) ? Q_ONE : prod_reg[23:8];
        trk_new   = (ram_rdata > trk_v) ? ram_rdata : trk_v;
    end

    assign stat.trk_ok = ctl_ok && mot_ok && off_ok;

    // remap with swap
    always_comb
    begin
        found = 1'b0;
        for (int c = 0; c < CONTROLLERS; c++)
        begin
            map_valid_next[c] = map_valid_reg[c];
            map_idx_next[c]   = map_idx_reg[c];
        end
        if (cmd.accept && kind == KIND_REMAP && ctl_ok)
        begin
            if (physical[2])
            begin
                map_valid_next[ctl_i] = 1'b0;
            end
            else if (int'(phys_p) < CONTROLLERS)
            begin
                for (int c = 0; c < CONTROLLERS; c++)
                begin
                    if (!found && map_valid_reg[c] && map_idx_reg[c] == CW'(phys_p))
                    begin
                        found             = 1'b1;
                        map_valid_next[c] = map_valid_reg[ctl_i];
                        map_idx_next[c]   = map_idx_reg[ctl_i];
                    end
                end
                map_valid_next[ctl_i] = 1'b1;
                map_idx_next[ctl_i]   = CW'(phys_p);
            end
        end
    end

    // restoring divider step, quotient also kept modulo ring depth
    always_comb
    begin
        period_eff = (sample_period_us == '0) ? PERIOD_W'(1) : sample_period_us;
        rem_sh     = {rem_reg, dvd_reg[DIV_W-1]};
        q_bit      = rem_sh >= {1'b0, period_eff};
        rem_nx     = q_bit ? PERIOD_W'(rem_sh - {1'b0, period_eff}) : PERIOD_W'(rem_sh);
        qmod_sh    = {qmod_reg, q_bit};
        qmod_nx    = (qmod_sh >= DEPTH_X) ? SW'(qmod_sh - DEPTH_X) : SW'(qmod_sh);
        pos_sum    = {1'b0, pos_reg} + {1'b0, qmod_reg};
        pos_nx     = (pos_sum >= DEPTH_X) ? SW'(pos_sum - DEPTH_X) : SW'(pos_sum);
    end

    assign stat.div_last = (dcnt_reg == '0);
    assign stat.clr_zero = (quo_reg == '0);

    // clear and emit walks
    always_comb
    begin
        clr_m_last  = (clr_m_reg == M_LAST);
        clr_c_last  = (clr_c_reg == C_LAST);
        emit_m_last = (emit_m_reg == M_LAST);
        emit_p_last = (emit_p_reg == C_LAST);
        sel_c       = '0;
        sel_hit     = 1'b0;
        // highest enabled controller mapped here wins
        for (int c = 0; c < CONTROLLERS; c++)
        begin
            if (c < MASK_W && enable_mask[c % MASK_W] && map_valid_reg[c]
                && map_idx_reg[c] == emit_p_reg)
            begin
                sel_c   = CW'(c);
                sel_hit = 1'b1;
            end
        end
    end

    assign stat.init_last = (init_cnt_reg == '1);
    assign stat.clr_last  = clr_m_last && clr_c_last && (clr_left_reg == CLW'(1));
    assign stat.emit_last = emit_m_last && emit_p_last;

    // ring memory ports
    always_comb
    begin
        ram_we    = cmd.init || cmd.trk_wr || cmd.clr;
        ram_waddr = {clr_c_reg, clr_m_reg, clr_slot_reg};
        ram_wdata = '0;
        if (cmd.init)
        begin
            ram_waddr = init_cnt_reg;
        end
        else if (cmd.trk_wr)
        begin
            ram_waddr = trk_addr_reg;
            ram_wdata = trk_new;
        end
        ram_raddr = cmd.emit ? {sel_c, emit_m_reg, pos_reg} : trk_addr;
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CONTROLLERS; c++)
            begin
                map_valid_reg[c] <= 1'b1;
                map_idx_reg[c]   <= CW'(c);
                for (int m = 0; m < MOTORS; m++)
                begin
                    str_reg[c][m] <= '0;
                end
            end
            pos_reg      <= '0;
            acc_reg      <= '0;
            init_cnt_reg <= '0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CONTROLLERS; c++)
            begin
                map_valid_reg[c] <= map_valid_next[c];
                map_idx_reg[c]   <= map_idx_next[c];
            end
            if (cmd.accept && kind == KIND_STRENGTH && ctl_ok && mot_ok)
            begin
                str_reg[ctl_i][mot_i] <= level_sat;
            end
            if (cmd.init)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (cmd.setup)
            begin
                acc_reg <= rem_reg;
                pos_reg <= pos_nx;
            end
            st_valid_reg <= cmd.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            trk_addr_reg <= trk_addr;
            prod_reg     <= level_sat * scale;
            dvd_reg      <= DIV_W'(acc_reg) + DIV_W'(elapsed_us);
            rem_reg      <= '0;
            quo_reg      <= '0;
            qmod_reg     <= '0;
            dcnt_reg     <= DIV_CNT_W'(DIV_W - 1);
        end
        if (cmd.div)
        begin
            dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg  <= rem_nx;
            quo_reg  <= {quo_reg[DIV_W-2:0], q_bit};
            qmod_reg <= qmod_nx;
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.setup)
        begin
            clr_left_reg <= (quo_reg >= DIV_W'(RING_DEPTH)) ? CLW'(RING_DEPTH)
                                                            : CLW'(quo_reg);
            clr_slot_reg <= pos_reg;
            clr_c_reg    <= '0;
            clr_m_reg    <= '0;
            emit_p_reg   <= '0;
            emit_m_reg   <= '0;
        end
        if (cmd.clr)
        begin
            clr_m_reg <= clr_m_last ? '0 : clr_m_reg + MW'(1);
            if (clr_m_last)
            begin
                clr_c_reg <= clr_c_last ? '0 : clr_c_reg + CW'(1);
                if (clr_c_last)
                begin
                    clr_slot_reg <= (clr_slot_reg == S_LAST) ? '0 : clr_slot_reg + SW'(1);
                    clr_left_reg <= clr_left_reg - CLW'(1);
                end
            end
        end
        if (cmd.emit)
        begin
            emit_m_reg <= emit_m_last ? '0 : emit_m_reg + MW'(1);
            if (emit_m_last)
            begin
                emit_p_reg <= emit_p_reg + CW'(1);
            end
            st_p_reg    <= emit_p_reg;
            st_m_reg    <= emit_m_reg;
            st_hit_reg  <= sel_hit;
            st_str_reg  <= str_reg[sel_c][emit_m_reg];
            st_last_reg <= emit_m_last && emit_p_last;
        end
    end

    // result word
    assign valid        = st_valid_reg;
    assign physical_out = 2'(st_p_reg);
    assign motor_out    = 1'(st_m_reg);
    assign last         = st_valid_reg && st_last_reg;
    assign drive        = !st_hit_reg ? '0
                        : ((st_str_reg > ram_rdata) ? st_str_reg : ram_rdata);

endmodule

`default_nettype wire

### rtl/core/haptic_vibration_mixer_unit.sv
// Strength and remap words are taken without going busy. A track word with a valid
// target adds a write back with busy high. Update word: a 21-bit divide, a setup
// step, CONTROLLERS*MOTORS ring entries cleared per slot (at most RING_DEPTH slots),
// then one drive word per cycle; the receiver cannot stall.
// After reset the ring memory is swept to zero, one entry a cycle
// (2**(ctrl bits + motor bits + slot bits) entries, 512 by default) with busy high.
`default_nettype none

module haptic_vibration_mixer_unit
    import hvm_pkg::*;
#(
    parameter int CONTROLLERS = 4,
    parameter int MOTORS      = 2,
    parameter int RING_DEPTH  = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           kind,
    input  wire logic [1:0]           controller,
    input  wire logic                 motor,
    input  wire logic [LEVEL_W-1:0]   level,
    input  wire logic [15:0]          scale,
    input  wire logic [5:0]           offset,
    input  wire logic signed [2:0]    physical,
    input  wire logic [PERIOD_W-1:0]  elapsed_us,

    // result channel, one word per strobe
    output logic                      valid,
    output logic [1:0]                physical_out,
    output logic                      motor_out,
    output logic [LEVEL_W-1:0]        drive,
    output logic                      last,

    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // Registers: enable_mask at 0x0, sample_period_us at 0x4.
    logic [MASK_W-1:0]   enable_mask_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_wr;

    hvm_cmd_t  cmd;
    hvm_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= '0;
            period_reg      <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ENABLE_MASK)
            begin
                enable_mask_reg <= pwdata[MASK_W-1:0];
            end
            else
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SAMPLE_PERIOD) ? 32'(period_reg)
                                                    : 32'(enable_mask_reg);

    // Sequencer: sweep, item dispatch, divide, clear, emit.
    hvm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Strength store, map table, ring memory, time divider and drive stage.
    hvm_datapath #(
        .CONTROLLERS (CONTROLLERS),
        .MOTORS      (MOTORS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .controller       (controller),
        .motor            (motor),
        .level            (level),
        .scale            (scale),
        .offset           (offset),
        .physical         (physical),
        .elapsed_us       (elapsed_us),
        .enable_mask      (enable_mask_reg),
        .sample_period_us (period_reg),
        .valid            (valid),
        .physical_out     (physical_out),
        .motor_out        (motor_out),
        .drive            (drive),
        .last             (last)
    );

    // Drive words only come out during an update run.
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("drive word outside update run");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> valid)
        else $error("last without strobe");

    // A run is contiguous up to its last word.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> valid)
        else $error("gap inside drive run");

    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_UPDATE) |=> busy)
        else $error("update accepted without going busy");

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

// Testbench for the rumble mixer: commands go in on the start/busy channel,
// drive words come back on valid strobes and are checked against a predictor
// that mirrors the strength store, the track ring, the controller map and
// the sample-period time base.
module tb_top;
    import hvm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCTL  = 4;
    localparam int NMOT  = 2;
    localparam int NSLOT = 64;

    // one command word
    typedef struct {
        kind_t             kind;
        logic [1:0]        controller;
        logic              motor;
        logic [15:0]       level;
        logic [15:0]       scale;
        logic [5:0]        offset;
        logic signed [2:0] physical;
        logic [19:0]       elapsed_us;
    } cmd_word_t;

    // one drive word
    typedef struct {
        logic [1:0]  physical_out;
        logic        motor_out;
        logic [15:0] drive;
        logic        last;
    } drive_word_t;

    // Predictor plus store of expected drive words.
    class drive_predictor;
        logic [15:0]  strength [NCTL][NMOT];
        logic [15:0]  track [NCTL][NMOT][NSLOT];
        logic [5:0]   ring_pos;
        int           ctl_map [NCTL];
        logic [31:0]  time_acc;
        logic [3:0]   en_mask;
        logic [19:0]  period_us;
        drive_word_t  expected_drive [$];
        int           errors;
        int           words_checked;
        int           updates;

        function new();
            foreach (strength[c, m])
                strength[c][m] = '0;
            foreach (track[c, m, s])
                track[c][m][s] = '0;
            foreach (ctl_map[c])
                ctl_map[c] = c;
            ring_pos = '0;
            time_acc = '0;
            en_mask = '0;
            period_us = PERIOD_RESET;
            errors = 0;
            words_checked = 0;
            updates = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_ENABLE_MASK)
                en_mask = val[3:0];
            else
                period_us = val[19:0];
        endfunction

        function logic [31:0] reg_value(logic idx);
            return (idx == REG_ENABLE_MASK) ? {28'd0, en_mask} : {12'd0, period_us};
        endfunction

        function logic [15:0] sat_q1(longint unsigned v);
            return (v > 32768) ? Q_ONE : v[15:0];
        endfunction

        function void advance(logic [19:0] elapsed);
            longint unsigned per, n, clears;
            per = (period_us == 0) ? 1 : period_us;
            time_acc = time_acc + elapsed;
            n = time_acc / per;
            time_acc = time_acc % per;
            clears = (n < NSLOT) ? n : NSLOT;
            for (int k = 0; k < clears; k++) begin
                foreach (strength[c, m])
                    track[c][m][ring_pos] = '0;
                ring_pos = ring_pos + 1'b1;
            end
            ring_pos = ring_pos + 6'((n - clears) % NSLOT);
        endfunction

        function void take_word(cmd_word_t w);
            logic [15:0] lvl, v, dmax [NCTL][NMOT];
            logic [5:0]  slot;
            int          p;
            lvl = sat_q1(w.level);
            case (w.kind)
                KIND_STRENGTH: strength[w.controller][w.motor] = lvl;
                KIND_REMAP: begin
                    if (w.physical < 0)
                        ctl_map[w.controller] = -1;
                    else begin
                        p = w.physical;
                        // whoever holds p takes over the old mapping
                        for (int c = 0; c < NCTL; c++)
                            if (ctl_map[c] == p) begin
                                ctl_map[c] = ctl_map[w.controller];
                                break;
                            end
                        ctl_map[w.controller] = p;
                    end
                end
                KIND_TRACK: begin
                    slot = ring_pos + 6'd1 + w.offset;
                    v = sat_q1((longint'(lvl) * w.scale) >> 8);
                    if (v > track[w.controller][w.motor][slot])
                        track[w.controller][w.motor][slot] = v;
                end
                default: begin
                    updates++;
                    advance(w.elapsed_us);
                    foreach (dmax[c, m])
                        dmax[c][m] = '0;
                    for (int c = 0; c < NCTL; c++) begin
                        p = ctl_map[c];
                        if (!en_mask[c] || p < 0)
                            continue;
                        for (int m = 0; m < NMOT; m++)
                            dmax[p][m] = (strength[c][m] > track[c][m][ring_pos]) ?
                                         strength[c][m] : track[c][m][ring_pos];
                    end
                    for (int c = 0; c < NCTL; c++)
                        for (int m = 0; m < NMOT; m++)
                            expected_drive.push_back('{c[1:0], m[0], dmax[c][m],
                                                       (c == NCTL-1 && m == NMOT-1)});
                end
            endcase
        endfunction

        task check_drive(drive_word_t got);
            drive_word_t exp;
            if (expected_drive.size() == 0) begin
                report($sformatf("unexpected drive word p=%0d m=%0d drive=%0d",
                                 got.physical_out, got.motor_out, got.drive));
                return;
            end
            exp = expected_drive.pop_front();
            words_checked++;
            if (got.physical_out !== exp.physical_out)
                report($sformatf("physical_out %0d, want %0d", got.physical_out,
                                 exp.physical_out));
            if (got.motor_out !== exp.motor_out)
                report($sformatf("motor_out %0d, want %0d", got.motor_out, exp.motor_out));
            if (got.drive !== exp.drive)
                report($sformatf("drive p=%0d m=%0d: %0d, want %0d", exp.physical_out,
                                 exp.motor_out, got.drive, exp.drive));
            if (got.last !== exp.last)
                report($sformatf("last %0b, want %0b", got.last, exp.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        kind;
    logic [1:0]        controller;
    logic              motor;
    logic [15:0]       level;
    logic [15:0]       scale;
    logic [5:0]        offset;
    logic signed [2:0] physical;
    logic [19:0]       elapsed_us;
    logic              valid;
    logic [1:0]        physical_out;
    logic              motor_out;
    logic [15:0]       drive;
    logic              last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    drive_predictor mixer_sb;

    haptic_vibration_mixer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .controller   (controller),
        .motor        (motor),
        .level        (level),
        .scale        (scale),
        .offset       (offset),
        .physical     (physical),
        .elapsed_us   (elapsed_us),
        .valid        (valid),
        .physical_out (physical_out),
        .motor_out    (motor_out),
        .drive        (drive),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // drive words can't be held off, so every strobe is checked right away
    always @(posedge clk)
    begin
        if (rst_n && valid)
            mixer_sb.check_drive('{physical_out, motor_out, drive, last});
    end

    // Present one command word and hold it until the block takes it.
    // Inputs move on the falling edge; busy is sampled on the rising edge.
    task send_word(cmd_word_t w);
        @(negedge clk);
        start      = 1'b1;
        kind       = w.kind;
        controller = w.controller;
        motor      = w.motor;
        level      = w.level;
        scale      = w.scale;
        offset     = w.offset;
        physical   = w.physical;
        elapsed_us = w.elapsed_us;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        mixer_sb.take_word(w);
    endtask

    task drop_start(int gap);
        @(negedge clk);
        start = 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    // Idle means no drive word outstanding and busy low; the extra cycles
    // cover a track merge still writing back.
    task wait_idle();
        while (mixer_sb.expected_drive.size() != 0)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        repeat (4) @(posedge clk);
    endtask

    // Setup then access phase; the write lands on the access edge. A read
    // back follows to check the stored value.
    task reg_write(logic idx, logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        mixer_sb.set_reg(idx, val);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        if (prdata !== mixer_sb.reg_value(idx))
            mixer_sb.report($sformatf("register %0d reads %0h, want %0h", idx, prdata,
                                      mixer_sb.reg_value(idx)));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic cmd_word_t mk_word(kind_t k, int c, int m, int lvl, int scl,
                                          int off, int phys, int el);
        cmd_word_t w;
        w.kind       = k;
        w.controller = c[1:0];
        w.motor      = m[0];
        w.level      = lvl[15:0];
        w.scale      = scl[15:0];
        w.offset     = off[5:0];
        w.physical   = phys[2:0];
        w.elapsed_us = el[19:0];
        return w;
    endfunction

    // Random word, weighted toward useful rumble traffic: strengths and
    // track samples near the read slot, updates stepping a few samples.
    function automatic cmd_word_t rand_word(int per);
        cmd_word_t w;
        int        pick;
        int        el;
        pick = $urandom_range(0, 99);
        w = mk_word(KIND_UPDATE, $urandom_range(0, 3), $urandom_range(0, 1),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 63), $urandom_range(0, 4) - 1, 0);
        if (pick < 20)
            w.kind = KIND_STRENGTH;
        else if (pick < 30)
            w.kind = KIND_REMAP;
        else if (pick < 65) begin
            w.kind = KIND_TRACK;
            if ($urandom_range(0, 3) != 0) begin
                w.offset = 6'($urandom_range(0, 4));
                w.level  = 16'($urandom_range(0, 32768));
                w.scale  = 16'($urandom_range(0, 512));
            end
        end
        if (w.kind == KIND_STRENGTH && $urandom_range(0, 2) != 0)
            w.level = 16'($urandom_range(0, 33000));
        if ($urandom_range(0, 4) == 0)
            el = $urandom_range(0, 1000000);
        else begin
            el = per * $urandom_range(0, 3) + $urandom_range(0, per / 2);
            if (el > 1000000)
                el = 1000000;
        end
        w.elapsed_us = el[19:0];
        return w;
    endfunction

    // Random bursts with random gaps; some bursts get no extra gap beyond dropping start.
    task run_phase(int mask, int per, int count);
        int sent;
        int burst;
        wait_idle();
        reg_write(REG_ENABLE_MASK, mask);
        reg_write(REG_SAMPLE_PERIOD, per);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++, sent++)
                send_word(rand_word(per));
            drop_start(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    cmd_word_t directed [$];

    initial
    begin
        mixer_sb = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_STRENGTH;
        controller = '0;
        motor      = 1'b0;
        level      = '0;
        scale      = '0;
        offset     = '0;
        physical   = '0;
        elapsed_us = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: level/scale extremes, saturation, both ends of the
        // offset window, remap swap and unmap, zero and max elapsed time
        directed.push_back(mk_word(KIND_UPDATE,   0, 0, 0,     0,     0,  0, 0));
        directed.push_back(mk_word(KIND_STRENGTH, 0, 0, 65535, 0,     0,  0, 0));
        directed.push_back(mk_word(KIND_STRENGTH, 0, 1, 32767, 0,     0,  0, 0));
        directed.push_back(mk_word(KIND_STRENGTH, 3, 1, 32768, 0,     0,  0, 0));
        directed.push_back(mk_word(KIND_STRENGTH, 2, 0, 0,     0,     0,  0, 0));
        directed.push_back(mk_word(KIND_TRACK,    1, 0, 65535, 65535, 0,  0, 0));
        directed.push_back(mk_word(KIND_TRACK,    1, 1, 1000,  0,     0,  0, 0));
        directed.push_back(mk_word(KIND_TRACK,    2, 1, 300,   1,     0,  0, 0));
        directed.push_back(mk_word(KIND_TRACK,    2, 1, 20000, 256,   63, 0, 0));
        directed.push_back(mk_word(KIND_TRACK,    2, 1, 10000, 256,   63, 0, 0));
        directed.push_back(mk_word(KIND_UPDATE,   0, 0, 0,     0,     0,  0, 0));
        directed.push_back(mk_word(KIND_UPDATE,   0, 0, 0,     0,     0,  0, 62500));
        directed.push_back(mk_word(KIND_REMAP,    0, 0, 0,     0,     0,  3, 0));
        directed.push_back(mk_word(KIND_REMAP,    1, 0, 0,     0,     0, -1, 0));
        directed.push_back(mk_word(KIND_REMAP,    2, 0, 0,     0,     0,  2, 0));
        directed.push_back(mk_word(KIND_UPDATE,   0, 0, 0,     0,     0,  0, 62499));
        directed.push_back(mk_word(KIND_REMAP,    1, 0, 0,     0,     0,  0, 0));
        directed.push_back(mk_word(KIND_UPDATE,   3, 1, 0,     0,     0,  0, 1000000));
        directed.push_back(mk_word(KIND_UPDATE,   0, 0, 0,     0,     0,  0, 1));

        wait_idle();
        reg_write(REG_ENABLE_MASK, 4'hF);
        reg_write(REG_SAMPLE_PERIOD, 62500);
        foreach (directed[i])
            send_word(directed[i]);
        drop_start(0);

        // random phases across mask and period settings, extremes included
        run_phase(4'hF, 62500, 60);
        run_phase($urandom_range(0, 15), 1, 30);
        run_phase(4'hF, 1000000, 40);
        run_phase(4'h0, 300, 20);
        run_phase($urandom_range(0, 15), 5000, 70);
        run_phase(4'h5, 20, 30);

        wait_idle();
        repeat (600) @(posedge clk);

        $display("covered %0d update runs, %0d drive words checked, %0d mismatches",
                 mixer_sb.updates, mixer_sb.words_checked, mixer_sb.errors);
        if (mixer_sb.errors == 0 && mixer_sb.expected_drive.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #30_000_000;
        $display("timeout waiting for the block");
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
